// File: design/assert_macros.svh
// Assertion macros shared by the chord name matcher RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CNM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CNM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

// File: design/cnm_pkg.sv
// Package for the chord name matcher: types, interval templates and helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cnm_pkg;

  localparam int NumStrings = 6;
  localparam int NumKinds   = 16;
  localparam int NumRoots   = 12;
  localparam int GroupSize  = 4;
  localparam int NumGroups  = NumRoots / GroupSize;
  localparam int MaxFretRow = 15;

  typedef logic [3:0]  pc_t;
  typedef logic [11:0] pcset_t;
  typedef logic [4:0]  code_t;

  typedef enum logic [1:0] {
    ST_NO_NOTES = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FOUND    = 2'd2
  } status_t;

  localparam pc_t TuningReset [NumStrings] = '{4'd4, 4'd9, 4'd2, 4'd7, 4'd11, 4'd4};

  // Bit i of a mask is the interval of i semitones above the root.
  localparam pcset_t KindMask [NumKinds] = '{
    12'h091, 12'h089, 12'h491, 12'h891, 12'h489, 12'h449, 12'h049, 12'h249,
    12'h111, 12'h085, 12'h0A1, 12'h291, 12'h289, 12'h095, 12'h495, 12'h48D
  };

  localparam logic [2:0] KindTones [NumKinds] = '{
    3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd4,
    3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5
  };

  typedef struct packed {
    logic [2:0] tones;
    logic [3:0] kind;
  } match_t;

  typedef struct packed {
    logic   valid;
    pcset_t pcs;
  } set_stage_t;

  typedef struct packed {
    logic                        valid;
    logic                        any;
    match_t [NumRoots-1:0]       best;
  } root_stage_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    pc_t     root;
    logic [3:0] kind;
    logic [2:0] tones;
  } result_t;

  // Remainder by twelve through a reciprocal multiply; exact for x below 128.
  function automatic pc_t mod12(input logic [6:0] x);
    logic [12:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = 13'(x) * 13'd43;
    q = p[12:9];
    r = x - 7'(q) * 7'd12;
    return r[3:0];
  endfunction

endpackage

// File: design/cnm_pitch_set.sv
// Pitch class set builder: per-string sums, then mod-12 decode into a set.
// Depends on cnm_pkg. Two register stages.
`timescale 1ns / 1ps

module cnm_pitch_set import cnm_pkg::*; #(
  parameter int MAX_FRET_ROW = MaxFretRow
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  code_t                        start_fret,
  input  code_t [NumStrings-1:0]       codes,
  input  pc_t   [NumStrings-1:0]       tuning,
  output set_stage_t                   set_out
);

  logic [NumStrings-1:0][6:0] sum_r, sum_nxt;
  logic [NumStrings-1:0]      snd_r, snd_nxt;
  logic                       v1_r;
  set_stage_t                 set_r, set_nxt;

  always_comb begin
    for (int s = 0; s < NumStrings; s++) begin
      code_t row;
      row = codes[s] - 5'd1;
      if (codes[s] == 5'd1) begin
        sum_nxt[s] = {3'b000, tuning[s]};
        snd_nxt[s] = 1'b1;
      end else begin
        sum_nxt[s] = {3'b000, tuning[s]} + {2'b00, start_fret} + 7'd11 + {2'b00, row};
        snd_nxt[s] = (codes[s] != 5'd0) && (row <= 5'(MAX_FRET_ROW));
      end
    end
  end

  always_comb begin
    set_nxt.valid = v1_r;
    set_nxt.pcs   = '0;
    for (int s = 0; s < NumStrings; s++) begin
      if (snd_r[s]) begin
        set_nxt.pcs = set_nxt.pcs | (pcset_t'(1) << mod12(sum_r[s]));
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    snd_r     <= snd_nxt;
    set_r.pcs <= set_nxt.pcs;
    if (!rst_n) begin
      v1_r        <= 1'b0;
      set_r.valid <= 1'b0;
    end else begin
      v1_r        <= in_valid;
      set_r.valid <= set_nxt.valid;
    end
  end

  assign set_out = set_r;

endmodule

// File: design/cnm_root_match.sv
// Per-root template matcher: rotates the set for each of the twelve roots
// and picks the best template per root. Depends on cnm_pkg. One register stage.
`timescale 1ns / 1ps

module cnm_root_match import cnm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  set_stage_t  set_in,
  output root_stage_t root_out
);

  // First template with the most tones among those contained in rot.
  function automatic match_t kind_pick(input pcset_t rot);
    logic [NumKinds-1:0] m;
    logic                h5, h4, h3;
    logic [3:0]          k5, k4, k3;
    match_t              res;
    h5 = 1'b0; h4 = 1'b0; h3 = 1'b0;
    k5 = '0;   k4 = '0;   k3 = '0;
    for (int k = 0; k < NumKinds; k++) begin
      m[k] = (rot & KindMask[k]) == KindMask[k];
    end
    for (int k = NumKinds - 1; k >= 0; k--) begin
      if (m[k] && KindTones[k] == 3'd5) begin
        h5 = 1'b1;
        k5 = 4'(k);
      end
      if (m[k] && KindTones[k] == 3'd4) begin
        h4 = 1'b1;
        k4 = 4'(k);
      end
      if (m[k] && KindTones[k] == 3'd3) begin
        h3 = 1'b1;
        k3 = 4'(k);
      end
    end
    if (h5) begin
      res = '{tones: 3'd5, kind: k5};
    end else if (h4) begin
      res = '{tones: 3'd4, kind: k4};
    end else if (h3) begin
      res = '{tones: 3'd3, kind: k3};
    end else begin
      res = '0;
    end
    return res;
  endfunction

  root_stage_t root_r, root_nxt;

  always_comb begin
    logic [23:0] dbl;
    dbl = {set_in.pcs, set_in.pcs};
    root_nxt.valid = set_in.valid;
    root_nxt.any   = |set_in.pcs;
    for (int r = 0; r < NumRoots; r++) begin
      // A pitch class that is not in the set cannot serve as root.
      if (set_in.pcs[r]) begin
        root_nxt.best[r] = kind_pick(dbl[r +: 12]);
      end else begin
        root_nxt.best[r] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    root_r.any  <= root_nxt.any;
    root_r.best <= root_nxt.best;
    if (!rst_n) begin
      root_r.valid <= 1'b0;
    end else begin
      root_r.valid <= root_nxt.valid;
    end
  end

  assign root_out = root_r;

endmodule

// File: design/cnm_select.sv
// Winner selection across roots: groups of four, then across the groups,
// with status formatting. Depends on cnm_pkg. Two register stages.
`timescale 1ns / 1ps

module cnm_select import cnm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  root_stage_t root_in,
  output result_t     res_out
);

  logic                        v4_r;
  logic                        any4_r, any4_nxt;
  match_t [NumGroups-1:0]      gbest_r, gbest_nxt;
  pc_t    [NumGroups-1:0]      groot_r, groot_nxt;
  result_t                     res_r, res_nxt;

  // Only a strictly larger tone count displaces an earlier root.
  always_comb begin
    any4_nxt = root_in.any;
    for (int g = 0; g < NumGroups; g++) begin
      gbest_nxt[g] = root_in.best[g * GroupSize];
      groot_nxt[g] = 4'(g * GroupSize);
      for (int j = 1; j < GroupSize; j++) begin
        if (root_in.best[g * GroupSize + j].tones > gbest_nxt[g].tones) begin
          gbest_nxt[g] = root_in.best[g * GroupSize + j];
          groot_nxt[g] = 4'(g * GroupSize + j);
        end
      end
    end
  end

  always_comb begin
    match_t win;
    pc_t    win_root;
    win      = gbest_r[0];
    win_root = groot_r[0];
    for (int g = 1; g < NumGroups; g++) begin
      if (gbest_r[g].tones > win.tones) begin
        win      = gbest_r[g];
        win_root = groot_r[g];
      end
    end
    res_nxt.valid = v4_r;
    if (!any4_r) begin
      res_nxt.status = ST_NO_NOTES;
      res_nxt.root   = '0;
      res_nxt.kind   = '0;
      res_nxt.tones  = '0;
    end else if (win.tones == 3'd0) begin
      res_nxt.status = ST_NO_MATCH;
      res_nxt.root   = '0;
      res_nxt.kind   = '0;
      res_nxt.tones  = '0;
    end else begin
      res_nxt.status = ST_FOUND;
      res_nxt.root   = win_root;
      res_nxt.kind   = win.kind;
      res_nxt.tones  = win.tones;
    end
  end

  always_ff @(posedge clk) begin
    any4_r       <= any4_nxt;
    gbest_r      <= gbest_nxt;
    groot_r      <= groot_nxt;
    res_r.status <= res_nxt.status;
    res_r.root   <= res_nxt.root;
    res_r.kind   <= res_nxt.kind;
    res_r.tones  <= res_nxt.tones;
    if (!rst_n) begin
      v4_r        <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      v4_r        <= root_in.valid;
      res_r.valid <= res_nxt.valid;
    end
  end

  assign res_out = res_r;

endmodule

// File: design/chord_name_matcher_top.sv
// Top level of the chord name matcher: tuning registers, configuration port,
// and the five-stage pipeline. Depends on cnm_pkg and the cnm_* stage modules.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  Channel   Handshake               Payload
//  ------    ---------------------   ------------------------------------------
//  input     start & !busy           in_start_fret, in_string0..5_code
//  result    out_valid (one cycle)   out_status, out_root_class, out_chord_kind,
//                                    out_tone_count
//  config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
//  One shape is taken every cycle while busy is low; its result passes through
//  the registered stages in order: string sums, set decode, per-root template
//  match, group reduction, final selection. busy comes from a register that is
//  set during reset and cleared once reset is released.
//  Reset is synchronous and clears the valid bits and restores the tunings.
//  The receiver cannot stall, so the pipeline never holds.

module chord_name_matcher_top import cnm_pkg::*; #(
  parameter int MAX_FRET_ROW = MaxFretRow
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [4:0] in_start_fret,
  input  logic [4:0] in_string0_code,
  input  logic [4:0] in_string1_code,
  input  logic [4:0] in_string2_code,
  input  logic [4:0] in_string3_code,
  input  logic [4:0] in_string4_code,
  input  logic [4:0] in_string5_code,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [3:0] out_root_class,
  output logic [3:0] out_chord_kind,
  output logic [2:0] out_tone_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data
);

  pc_t   tuning_r [NumStrings];
  pc_t   tuning_nxt [NumStrings];
  logic  busy_r, busy_nxt;
  logic  in_xfer;
  code_t [NumStrings-1:0] codes;
  pc_t   [NumStrings-1:0] tuning_vec;
  set_stage_t  set_s;
  root_stage_t root_s;
  result_t     res_s;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign busy_nxt  = 1'b0;
  assign in_xfer   = start && !busy_r;

  always_comb begin
    for (int s = 0; s < NumStrings; s++) begin
      tuning_nxt[s] = tuning_r[s];
    end
    // Writes to indexes past the last string are dropped.
    if (cfg_valid && cfg_ready && cfg_index < 3'(NumStrings)) begin
      tuning_nxt[cfg_index] = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      for (int s = 0; s < NumStrings; s++) begin
        tuning_r[s] <= TuningReset[s];
      end
    end else begin
      busy_r <= busy_nxt;
      for (int s = 0; s < NumStrings; s++) begin
        tuning_r[s] <= tuning_nxt[s];
      end
    end
  end

  assign codes = {in_string5_code, in_string4_code, in_string3_code,
                  in_string2_code, in_string1_code, in_string0_code};

  always_comb begin
    for (int s = 0; s < NumStrings; s++) begin
      tuning_vec[s] = tuning_r[s];
    end
  end

  cnm_pitch_set #(
    .MAX_FRET_ROW (MAX_FRET_ROW)
  ) u_pitch_set (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_xfer),
    .start_fret (in_start_fret),
    .codes      (codes),
    .tuning     (tuning_vec),
    .set_out    (set_s)
  );

  cnm_root_match u_root_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .set_in   (set_s),
    .root_out (root_s)
  );

  cnm_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .root_in (root_s),
    .res_out (res_s)
  );

  assign out_valid      = res_s.valid;
  assign out_status     = res_s.status;
  assign out_root_class = res_s.root;
  assign out_chord_kind = res_s.kind;
  assign out_tone_count = res_s.tones;

  `CNM_ASSERT_NXT(a_latency, clk, rst_n, in_xfer, ##4 out_valid, "result missing after transfer")
  `CNM_ASSERT_IMP(a_origin, clk, rst_n, out_valid, $past(in_xfer, 5), "result without a transfer")
  `CNM_ASSERT_IMP(a_zero_fields, clk, rst_n, out_valid && res_s.status != ST_FOUND, out_root_class == 4'd0 && out_chord_kind == 4'd0 && out_tone_count == 3'd0, "fields not cleared without a chord")

endmodule

// File: sim/tb_chord_name_matcher_top.sv
// Self-checking testbench for chord_name_matcher_top: drives fretboard shapes
// and tuning writes, predicts each chord name and checks every result.
// Depends on cnm_pkg and the chord_name_matcher_top RTL.
`timescale 1ns / 1ps

module tb_chord_name_matcher_top;
  import cnm_pkg::*;

  localparam int STRINGS      = 6;
  localparam int KINDS        = 16;
  localparam int MAX_FRET_ROW = 15;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASES       = 8;
  localparam int RANDOM_SHAPES_PER_PHASE = 97;

  localparam logic [4:0] CODE_MUTED = 5'd0;
  localparam logic [4:0] CODE_OPEN  = 5'd1;

  localparam logic [2:0] REG_STRING0 = 3'd0;
  localparam logic [2:0] REG_COUNT   = 3'd6;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // Interval templates, bit i set for an interval of i semitones above the root.
  localparam logic [11:0] CHORD_MASK [KINDS] = '{
    (12'd1 << 0) | (12'd1 << 4) | (12'd1 << 7),                               // major
    (12'd1 << 0) | (12'd1 << 3) | (12'd1 << 7),                               // minor
    (12'd1 << 0) | (12'd1 << 4) | (12'd1 << 7) | (12'd1 << 10),               // dom7
    (12'd1 << 0) | (12'd1 << 4) | (12'd1 << 7) | (12'd1 << 11),               // maj7
    (12'd1 << 0) | (12'd1 << 3) | (12'd1 << 7) | (12'd1 << 10),               // m7
    (12'd1 << 0) | (12'd1 << 3) | (12'd1 << 6) | (12'd1 << 10),               // m7b5
    (12'd1 << 0) | (12'd1 << 3) | (12'd1 << 6),                               // dim
    (12'd1 << 0) | (12'd1 << 3) | (12'd1 << 6) | (12'd1 << 9),                // dim7
    (12'd1 << 0) | (12'd1 << 4) | (12'd1 << 8),                               // aug
    (12'd1 << 0) | (12'd1 << 2) | (12'd1 << 7),                               // sus2
    (12'd1 << 0) | (12'd1 << 5) | (12'd1 << 7),                               // sus4
    (12'd1 << 0) | (12'd1 << 4) | (12'd1 << 7) | (12'd1 << 9),                // six
    (12'd1 << 0) | (12'd1 << 3) | (12'd1 << 7) | (12'd1 << 9),                // m6
    (12'd1 << 0) | (12'd1 << 2) | (12'd1 << 4) | (12'd1 << 7),                // add9
    (12'd1 << 0) | (12'd1 << 2) | (12'd1 << 4) | (12'd1 << 7) | (12'd1 << 10), // nine
    (12'd1 << 0) | (12'd1 << 2) | (12'd1 << 3) | (12'd1 << 7) | (12'd1 << 10)  // m9
  };

  typedef struct packed {
    logic [4:0]      fret;
    logic [5:0][4:0] code;
  } shape_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] root;
    logic [3:0] kind;
    logic [2:0] tones;
  } chord_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [4:0] in_start_fret = '0;
  logic [4:0] in_string0_code = '0;
  logic [4:0] in_string1_code = '0;
  logic [4:0] in_string2_code = '0;
  logic [4:0] in_string3_code = '0;
  logic [4:0] in_string4_code = '0;
  logic [4:0] in_string5_code = '0;
  logic       out_valid;
  logic [1:0] out_status;
  logic [3:0] out_root_class;
  logic [3:0] out_chord_kind;
  logic [2:0] out_tone_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  logic [3:0] open_pitch [STRINGS] = '{4'd4, 4'd9, 4'd2, 4'd7, 4'd11, 4'd4};

  shape_t shapes_to_play [$];
  chord_t chord_answers [$];
  int     shapes_queued = 0;
  int     shapes_played = 0;
  int     mismatches = 0;
  int     quiet_cycles = 0;

  chord_name_matcher_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_fret  (in_start_fret),
    .in_string0_code(in_string0_code),
    .in_string1_code(in_string1_code),
    .in_string2_code(in_string2_code),
    .in_string3_code(in_string3_code),
    .in_string4_code(in_string4_code),
    .in_string5_code(in_string5_code),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_root_class (out_root_class),
    .out_chord_kind (out_chord_kind),
    .out_tone_count (out_tone_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic chord_t name_chord(input shape_t sh);
    logic [11:0] notes;
    logic [11:0] turned;
    int          best_tones;
    int          tones;
    int          row;
    chord_t      c;
    notes = '0;
    turned = '0;
    best_tones = 0;
    c.status = ST_NO_NOTES;
    c.root = '0;
    c.kind = '0;
    c.tones = '0;
    for (int s = 0; s < STRINGS; s++) begin
      row = int'(sh.code[s]) - 1;
      if (sh.code[s] == CODE_OPEN) begin
        notes[open_pitch[s] % 12] = 1'b1;
      end else if (sh.code[s] != CODE_MUTED && row <= MAX_FRET_ROW) begin
        notes[(int'(open_pitch[s]) + int'(sh.fret) + 11 + row) % 12] = 1'b1;
      end
    end
    if (notes == '0) return c;
    c.status = ST_NO_MATCH;
    for (int r = 0; r < 12; r++) begin
      if (notes[r]) begin
        for (int i = 0; i < 12; i++) turned[i] = notes[(i + r) % 12];
        // Only a strictly larger match displaces the current one.
        for (int k = 0; k < KINDS; k++) begin
          tones = $countones(CHORD_MASK[k]);
          if ((turned & CHORD_MASK[k]) == CHORD_MASK[k] && tones > best_tones) begin
            best_tones = tones;
            c.status = ST_FOUND;
            c.root = 4'(r);
            c.kind = 4'(k);
            c.tones = 3'(tones);
          end
        end
      end
    end
    return c;
  endfunction

  function automatic logic [4:0] pick_fret();
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 5'd0
                                                                      : 5'($urandom_range(25, 31));
    return 5'($urandom_range(1, 24));
  endfunction

  function automatic logic [4:0] noise_code();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick < 2) return CODE_MUTED;
    if (pick == 2) return CODE_OPEN;
    if (pick == 7) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(2, 16));
  endfunction

  // Lays the template's tones on consecutive strings and fills the rest
  // with muted strings or doubled chord tones.
  function automatic shape_t voice_chord(input int root, input int kind, input logic [4:0] fret);
    shape_t sh;
    int     degrees [$];
    int     first;
    int     target;
    int     row;
    int     tune;
    for (int i = 0; i < 12; i++) if (CHORD_MASK[kind][i]) degrees.push_back(i);
    sh.fret = fret;
    sh.code = '0;
    first = $urandom_range(0, STRINGS - degrees.size());
    for (int s = 0; s < STRINGS; s++) begin
      tune = int'(open_pitch[s] % 12);
      if (s >= first && s < first + degrees.size()) begin
        target = root + degrees[s - first];
      end else if ($urandom_range(0, 2) == 0) begin
        continue;
      end else begin
        target = root + degrees[$urandom_range(0, degrees.size() - 1)];
      end
      row = (((target - tune - int'(fret) - 11) % 12) + 12) % 12;
      if ((target - tune) % 12 == 0 && $urandom_range(0, 3) == 0) begin
        sh.code[s] = CODE_OPEN;
      end else begin
        if (row + 12 <= MAX_FRET_ROW && $urandom_range(0, 1) != 0) row += 12;
        sh.code[s] = 5'(row + 1);
      end
    end
    return sh;
  endfunction

  function automatic shape_t noise_shape();
    shape_t sh;
    sh.fret = 5'($urandom_range(0, 31));
    for (int s = 0; s < STRINGS; s++) sh.code[s] = noise_code();
    return sh;
  endfunction

  task automatic queue_shape(input shape_t sh);
    shapes_to_play.push_back(sh);
    shapes_queued++;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [3:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < REG_COUNT) open_pitch[idx] = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_until_idle();
    @(posedge clk);
    while (shapes_played != shapes_queued || chord_answers.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string what, input int got, input int want);
    if (got != want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Input driver: bursts of transfers separated by random gaps, and now and
  // then a pause until the pipeline has drained.
  always @(posedge clk) begin : shape_driver
    shape_t offered;
    int     burst_left;
    int     gap_left;
    bit     drain_hold;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = 1;
      gap_left = 0;
      drain_hold = 1'b0;
    end else begin
      if (start && !busy) begin
        chord_answers.push_back(name_chord(offered));
        shapes_played++;
      end
      if (!(start && busy)) begin
        if (drain_hold && chord_answers.size() != 0) begin
          start <= 1'b0;
        end else if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (shapes_to_play.size() == 0) begin
          start <= 1'b0;
        end else begin
          drain_hold = 1'b0;
          offered = shapes_to_play.pop_front();
          start <= 1'b1;
          in_start_fret <= offered.fret;
          in_string0_code <= offered.code[0];
          in_string1_code <= offered.code[1];
          in_string2_code <= offered.code[2];
          in_string3_code <= offered.code[3];
          in_string4_code <= offered.code[4];
          in_string5_code <= offered.code[5];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            drain_hold = ($urandom_range(0, 11) == 0);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Results are sampled mid-cycle, while the strobe is stable.
  always @(negedge clk) begin : result_check
    chord_t want;
    if (out_valid === 1'b1) begin
      if (chord_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d root %0d kind %0d tones %0d",
                 $time, out_status, out_root_class, out_chord_kind, out_tone_count);
        mismatches++;
      end else begin
        want = chord_answers.pop_front();
        compare_field("status", int'(out_status), int'(want.status));
        compare_field("root_class", int'(out_root_class), int'(want.root));
        compare_field("chord_kind", int'(out_chord_kind), int'(want.kind));
        compare_field("tone_count", int'(out_tone_count), int'(want.tones));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    shape_t     sh;
    logic [3:0] value;
    int         pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed shapes under the standard tuning.
    sh.fret = 5'd1;
    sh.code = '0;
    queue_shape(sh);
    sh.code = {5'd25, 5'd20, 5'd24, 5'd18, 5'd31, 5'd17};  // every row past the limit
    queue_shape(sh);
    sh.code = {CODE_OPEN, CODE_OPEN, CODE_OPEN, CODE_OPEN, CODE_OPEN, CODE_OPEN};
    queue_shape(sh);
    sh.code = {CODE_OPEN, CODE_OPEN, 5'd2, 5'd3, 5'd3, CODE_OPEN};  // open E major
    queue_shape(sh);
    sh.fret = 5'd24;
    sh.code = {5'd16, CODE_MUTED, CODE_MUTED, CODE_MUTED, CODE_MUTED, CODE_MUTED};
    queue_shape(sh);
    sh.fret = 5'd1;
    sh.code = {CODE_MUTED, CODE_MUTED, CODE_MUTED, CODE_MUTED, CODE_OPEN, CODE_OPEN};
    queue_shape(sh);
    queue_shape(voice_chord(0, 0, 5'd0));
    queue_shape(voice_chord(11, 14, 5'd31));
    for (int k = 0; k < KINDS; k++) queue_shape(voice_chord($urandom_range(0, 11), k, pick_fret()));

    for (int p = 0; p < PHASES; p++) begin
      wait_until_idle();
      if (p != 0) begin
        write_register((p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, 4'($urandom_range(0, 15)));
        for (int s = 0; s < STRINGS; s++) begin
          case (p)
            1: value = 4'd0;
            2: value = 4'd15;
            3: value = 4'd11;
            4: value = 4'(12 + s % 4);
            default: value = 4'($urandom_range(0, 15));
          endcase
          write_register(REG_STRING0 + 3'(s), value);
        end
      end
      for (int n = 0; n < RANDOM_SHAPES_PER_PHASE; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
          sh = voice_chord($urandom_range(0, 11), $urandom_range(0, KINDS - 1), pick_fret());
        end else if (pick < 14) begin
          sh = voice_chord($urandom_range(0, 11), $urandom_range(0, KINDS - 1), pick_fret());
          sh.code[$urandom_range(0, STRINGS - 1)] = noise_code();
        end else begin
          sh = noise_shape();
        end
        queue_shape(sh);
      end
    end

    wait_until_idle();
    repeat (10) @(posedge clk);
    if (chord_answers.size() != 0)
      $display("%0t: %0d results never arrived", $time, chord_answers.size());
    if (mismatches == 0 && chord_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
